### rtl/ptrc_pkg.sv
// ----------------------------------------------------------------------------
// ptrc_pkg
// Shared types and constants for the pre-trade risk check block.
// ----------------------------------------------------------------------------
package ptrc_pkg;

  localparam int NUM_INSTRUMENTS = 64;
  localparam int INST_IDX_W      = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DAILY_VOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPEN_INST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL_OPEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_MASK    = 3'd4;

  localparam logic ACTION_CHECK = 1'b0;
  localparam logic ACTION_FILL  = 1'b1;

  localparam logic [1:0] FILL_STATUS_FILLED  = 2'd1;
  localparam logic [1:0] FILL_STATUS_PARTIAL = 2'd2;

  typedef enum logic [2:0] {
    VERDICT_APPROVED     = 3'd0,
    VERDICT_ORDER_SIZE   = 3'd1,
    VERDICT_NOT_ALLOWED  = 3'd2,
    VERDICT_DAILY_VOLUME = 3'd3,
    VERDICT_INST_OPEN    = 3'd4,
    VERDICT_TOTAL_OPEN   = 3'd5
  } verdict_t;

  localparam logic [39:0] POS_MAX_40 = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] POS_MIN_40 = 40'h80_0000_0000;
  localparam logic [39:0] VOL_MAX_40 = 40'hFF_FFFF_FFFF;

endpackage

### rtl/pre_trade_risk_check.sv
// ----------------------------------------------------------------------------
// pre_trade_risk_check
// Per-instrument pre-trade risk gate with volume and position bookkeeping.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is either an order check or a fill
// report and yields exactly one result. The per-instrument memory is read
// at the transfer edge. Then come two evaluation stages, and a final stage
// that writes the memory back for an applied fill and loads the output
// register. One item is in flight at a time, and the input reopens at the
// edge that loads the result. A result that is still waiting holds back the
// final stage of the next item, and with it the following input. The
// per-instrument state is cleared at reset through a valid bit per entry, so
// no clearing pass is needed and the block accepts items from the first cycle
// after reset. Configuration writes are always taken and should be issued
// only while the block is idle.
module pre_trade_risk_check
  import ptrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [5:0]           in_instrument,
  input  logic [31:0]          in_quantity,
  input  logic                 in_sell,
  input  logic signed [39:0]   in_oms_position,
  input  logic [1:0]           in_fill_status,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_verdict,
  output logic signed [39:0]   out_position,
  output logic [39:0]          out_daily_volume,
  output logic [45:0]          out_total_open
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL1,
    S_EVAL2,
    S_DONE
  } state_t;

  localparam logic [6:0] NUM_INST_7 = 7'(NUM_INSTRUMENTS);

  // Configuration registers.
  logic [31:0] max_order_size_r;
  logic [39:0] max_daily_volume_r;
  logic [38:0] max_open_inst_r;
  logic [45:0] max_total_open_r;
  logic [63:0] allowed_mask_r;

  // Per-instrument memory: {daily volume, net position}.
  logic [79:0] inst_mem [NUM_INSTRUMENTS];
  logic [NUM_INSTRUMENTS-1:0] entry_vld_r;
  logic [79:0] rd_data_r;
  logic        rd_vld_r;

  // Control.
  state_t      state_r;
  logic        out_valid_r;
  logic [45:0] total_r;
  logic [2:0]  out_verdict_r;
  logic [39:0] out_position_r;
  logic [39:0] out_daily_volume_r;

  // Captured item.
  logic        item_action_r;
  logic [5:0]  item_inst_r;
  logic [31:0] item_qty_r;
  logic        item_sell_r;
  logic [39:0] item_oms_r;
  logic [1:0]  item_status_r;

  // First evaluation stage results.
  logic [39:0] cur_pos_r;
  logic [39:0] cur_vol_r;
  logic [40:0] np_raw_r;
  logic [40:0] oms_new_r;
  logic [39:0] old_abs_r;
  logic [40:0] vol_sum_r;
  logic        size_fail_r;
  logic        allow_fail_r;
  logic        do_fill_r;

  // Second evaluation stage results.
  logic [40:0] np_abs_r;
  logic [39:0] np_sat_r;
  logic [39:0] np_abs_sat_r;
  logic [45:0] base_r;
  logic [39:0] vol_sat_r;
  logic        vol_fail_r;
  logic        open_fail_r;

  logic [INST_IDX_W-1:0] in_idx;
  logic [INST_IDX_W-1:0] item_idx;
  logic                  in_fire;
  logic                  finish;

  // Stage 1 combinational values.
  logic [39:0] cur_pos;
  logic [39:0] cur_vol;
  logic [40:0] cur41;
  logic [40:0] oms41;
  logic [40:0] qty41;
  logic        inst_ok;

  // Stage 2 combinational values.
  logic        np_over;
  logic        np_under;
  logic [40:0] np_abs;
  logic [40:0] oms_abs;

  // Final stage combinational values.
  logic [46:0] total_chk;
  logic [45:0] total_fill;
  verdict_t    verdict;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign finish    = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_idx   = in_instrument[INST_IDX_W-1:0];
  assign item_idx = item_inst_r[INST_IDX_W-1:0];
  assign inst_ok  = ({1'b0, item_inst_r} < NUM_INST_7);

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_position     = out_position_r;
  assign out_daily_volume = out_daily_volume_r;
  assign out_total_open   = total_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_order_size_r   <= '0;
      max_daily_volume_r <= '0;
      max_open_inst_r    <= '0;
      max_total_open_r   <= '0;
      allowed_mask_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ORDER_SIZE: max_order_size_r   <= cfg_data[31:0];
        CFG_MAX_DAILY_VOL:  max_daily_volume_r <= cfg_data[39:0];
        CFG_MAX_OPEN_INST:  max_open_inst_r    <= cfg_data[38:0];
        CFG_MAX_TOTAL_OPEN: max_total_open_r   <= cfg_data[45:0];
        CFG_ALLOWED_MASK:   allowed_mask_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory: registered read on input transfer, write back at the end of a fill.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= inst_mem[in_idx];
    end
    if (finish && do_fill_r) begin
      inst_mem[item_idx] <= {vol_sat_r, np_sat_r};
    end
  end

  // An entry that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_vld_r <= entry_vld_r[in_idx];
      end
      if (finish && do_fill_r) begin
        entry_vld_r[item_idx] <= 1'b1;
      end
    end
  end

  // Stage 1: sums against the stored entry.
  always_comb begin
    cur_pos = (rd_vld_r && inst_ok) ? rd_data_r[39:0]  : '0;
    cur_vol = (rd_vld_r && inst_ok) ? rd_data_r[79:40] : '0;
    cur41   = {cur_pos[39], cur_pos};
    oms41   = {item_oms_r[39], item_oms_r};
    qty41   = {9'b0, item_qty_r};
  end

  // Stage 2: magnitudes and saturation.
  always_comb begin
    np_over  = !np_raw_r[40] && np_raw_r[39];
    np_under = np_raw_r[40] && !np_raw_r[39];
    np_abs   = np_raw_r[40] ? (41'd0 - np_raw_r) : np_raw_r;
    oms_abs  = oms_new_r[40] ? (41'd0 - oms_new_r) : oms_new_r;
  end

  // Final stage: total-open limit and verdict.
  always_comb begin
    total_chk  = {1'b0, base_r} + {6'b0, np_abs_r};
    total_fill = base_r + {6'b0, np_abs_sat_r};
    if (item_action_r == ACTION_FILL) begin
      verdict = VERDICT_APPROVED;
    end else if (size_fail_r) begin
      verdict = VERDICT_ORDER_SIZE;
    end else if (allow_fail_r) begin
      verdict = VERDICT_NOT_ALLOWED;
    end else if (vol_fail_r) begin
      verdict = VERDICT_DAILY_VOLUME;
    end else if (open_fail_r) begin
      verdict = VERDICT_INST_OPEN;
    end else if (total_chk > {1'b0, max_total_open_r}) begin
      verdict = VERDICT_TOTAL_OPEN;
    end else begin
      verdict = VERDICT_APPROVED;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_action_r <= in_action;
      item_inst_r   <= in_instrument;
      item_qty_r    <= in_quantity;
      item_sell_r   <= in_sell;
      item_oms_r    <= in_oms_position;
      item_status_r <= in_fill_status;
    end
    if (state_r == S_EVAL1) begin
      cur_pos_r    <= cur_pos;
      cur_vol_r    <= cur_vol;
      np_raw_r     <= item_sell_r ? (cur41 - qty41) : (cur41 + qty41);
      oms_new_r    <= item_sell_r ? (oms41 - qty41) : (oms41 + qty41);
      old_abs_r    <= cur_pos[39] ? (40'd0 - cur_pos) : cur_pos;
      vol_sum_r    <= {1'b0, cur_vol} + {9'b0, item_qty_r};
      size_fail_r  <= item_qty_r > max_order_size_r;
      allow_fail_r <= !inst_ok ||
                      ((allowed_mask_r != 64'd0) && !allowed_mask_r[item_inst_r]);
      do_fill_r    <= (item_action_r == ACTION_FILL) && inst_ok &&
                      ((item_status_r == FILL_STATUS_FILLED) ||
                       (item_status_r == FILL_STATUS_PARTIAL)) &&
                      (item_qty_r != 32'd0);
    end
    if (state_r == S_EVAL2) begin
      np_abs_r     <= np_abs;
      np_sat_r     <= np_over ? POS_MAX_40 : (np_under ? POS_MIN_40 : np_raw_r[39:0]);
      np_abs_sat_r <= np_over ? POS_MAX_40 : (np_under ? POS_MIN_40 : np_abs[39:0]);
      base_r       <= (total_r >= {6'b0, old_abs_r}) ? (total_r - {6'b0, old_abs_r})
                                                     : 46'd0;
      vol_sat_r    <= vol_sum_r[40] ? VOL_MAX_40 : vol_sum_r[39:0];
      vol_fail_r   <= vol_sum_r > {1'b0, max_daily_volume_r};
      open_fail_r  <= oms_abs > {2'b0, max_open_inst_r};
    end
  end

  // Sequencer, running total and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (out_valid_r && out_ready && !finish) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EVAL1;
          end
        end
        S_EVAL1: begin
          state_r <= S_EVAL2;
        end
        S_EVAL2: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (finish) begin
            state_r            <= S_IDLE;
            out_valid_r        <= 1'b1;
            out_verdict_r      <= verdict;
            out_position_r     <= do_fill_r ? np_sat_r  : cur_pos_r;
            out_daily_volume_r <= do_fill_r ? vol_sat_r : cur_vol_r;
            if (do_fill_r) begin
              total_r <= total_fill;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/pre_trade_risk_check_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pre_trade_risk_check_tb
// Self-checking bench for the pre-trade risk gate. A short table of directed
// orders and fills runs first, followed by random traffic under several limit
// settings. Every result is checked against a hand-written value or against
// a software copy of the volume and position book.
// ----------------------------------------------------------------------------
module pre_trade_risk_check_tb;
  import ptrc_pkg::*;

  localparam logic [1:0] FILL_STATUS_OTHER = 2'd0;
  localparam logic [1:0] FILL_STATUS_SPARE = 2'd3;
  localparam logic [5:0] HOT_LONG          = 6'd17;
  localparam logic [5:0] HOT_SHORT         = 6'd42;

  typedef struct packed {
    logic               action;
    logic [5:0]         inst;
    logic [31:0]        qty;
    logic               sell;
    logic signed [39:0] oms;
    logic [1:0]         status;
  } order_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic signed [39:0] pos;
    logic [39:0]        vol;
    logic [45:0]        total;
  } risk_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [63:0]          reg_val;
    order_t               ord;
    logic                 typed;
    risk_result_t         want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [5:0]           in_instrument;
  logic [31:0]          in_quantity;
  logic                 in_sell;
  logic signed [39:0]   in_oms_position;
  logic [1:0]           in_fill_status;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_verdict;
  logic signed [39:0]   out_position;
  logic [39:0]          out_daily_volume;
  logic [45:0]          out_total_open;

  // Software copy of the limits and of the per-instrument book.
  logic [31:0]        lim_order;
  logic [39:0]        lim_daily;
  logic [38:0]        lim_open;
  logic [45:0]        lim_total;
  logic [63:0]        allow_mask;
  logic [39:0]        vol_book [64];
  logic signed [39:0] pos_book [64];
  logic [45:0]        open_sum;

  risk_result_t pending_results [$];
  dir_row_t     directed_rows [$];
  int           errors;
  int           stall_left = 0;
  bit           steady;

  pre_trade_risk_check u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_instrument    (in_instrument),
    .in_quantity      (in_quantity),
    .in_sell          (in_sell),
    .in_oms_position  (in_oms_position),
    .in_fill_status   (in_fill_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_position     (out_position),
    .out_daily_volume (out_daily_volume),
    .out_total_open   (out_total_open)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic void set_limit(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_MAX_ORDER_SIZE: lim_order  = val[31:0];
      CFG_MAX_DAILY_VOL:  lim_daily  = val[39:0];
      CFG_MAX_OPEN_INST:  lim_open   = val[38:0];
      CFG_MAX_TOTAL_OPEN: lim_total  = val[45:0];
      CFG_ALLOWED_MASK:   allow_mask = val;
      default: ;
    endcase
  endfunction

  // Applies one order or fill to the book and returns the result it yields.
  function automatic risk_result_t predict_risk(order_t o);
    risk_result_t r;
    longint       cur;
    longint       delta;
    longint       np;
    logic [63:0]  base;
    logic [63:0]  vol;
    r.verdict = VERDICT_APPROVED;
    cur   = longint'($signed(pos_book[o.inst]));
    delta = o.sell ? -longint'({32'd0, o.qty}) : longint'({32'd0, o.qty});
    // Total without this instrument, so its new magnitude can be added back.
    base  = (64'(open_sum) >= magnitude(cur)) ? 64'(open_sum) - magnitude(cur) : 64'd0;
    if (o.action == ACTION_CHECK) begin
      if (o.qty > lim_order)
        r.verdict = VERDICT_ORDER_SIZE;
      else if (allow_mask != 64'd0 && !allow_mask[o.inst])
        r.verdict = VERDICT_NOT_ALLOWED;
      else if (64'(vol_book[o.inst]) + 64'(o.qty) > 64'(lim_daily))
        r.verdict = VERDICT_DAILY_VOLUME;
      else if (magnitude(longint'($signed(o.oms)) + delta) > 64'(lim_open))
        r.verdict = VERDICT_INST_OPEN;
      else if (base + magnitude(cur + delta) > 64'(lim_total))
        r.verdict = VERDICT_TOTAL_OPEN;
    end else if ((o.status == FILL_STATUS_FILLED || o.status == FILL_STATUS_PARTIAL) &&
                 o.qty != 32'd0) begin
      vol = 64'(vol_book[o.inst]) + 64'(o.qty);
      if (vol > 64'(VOL_MAX_40))
        vol = 64'(VOL_MAX_40);
      np = cur + delta;
      if (np > longint'($signed(POS_MAX_40)))
        np = longint'($signed(POS_MAX_40));
      if (np < longint'($signed(POS_MIN_40)))
        np = longint'($signed(POS_MIN_40));
      vol_book[o.inst] = vol[39:0];
      pos_book[o.inst] = np[39:0];
      open_sum = 46'(base + magnitude(np));
    end
    r.pos   = pos_book[o.inst];
    r.vol   = vol_book[o.inst];
    r.total = open_sum;
    return r;
  endfunction

  function automatic void add_item(logic action, logic [5:0] inst, logic [31:0] qty,
                                   logic sell, logic signed [39:0] oms, logic [1:0] status);
    dir_row_t row;
    row = '0;
    row.ord.action = action;
    row.ord.inst   = inst;
    row.ord.qty    = qty;
    row.ord.sell   = sell;
    row.ord.oms    = oms;
    row.ord.status = status;
    directed_rows.push_back(row);
  endfunction

  // Same as add_item, with the result written out by hand.
  function automatic void add_known(logic action, logic [5:0] inst, logic [31:0] qty,
                                    logic sell, logic signed [39:0] oms, logic [1:0] status,
                                    logic [2:0] verdict, logic signed [39:0] pos,
                                    logic [39:0] vol, logic [45:0] total);
    dir_row_t row;
    add_item(action, inst, qty, sell, oms, status);
    row = directed_rows.pop_back();
    row.typed         = 1'b1;
    row.want.verdict  = verdict;
    row.want.pos      = pos;
    row.want.vol      = vol;
    row.want.total    = total;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  function automatic order_t rand_order(bit hot);
    order_t t;
    if (hot) begin
      t.action = ($urandom_range(19) == 0) ? ACTION_CHECK : ACTION_FILL;
      t.inst   = $urandom_range(1) ? HOT_LONG : HOT_SHORT;
      t.qty    = 32'hFFFF_FFFF - $urandom_range(255);
      t.sell   = (t.inst == HOT_SHORT) ^ ($urandom_range(19) == 0);
    end else begin
      t.action = ($urandom_range(99) < 45) ? ACTION_FILL : ACTION_CHECK;
      t.inst   = $urandom_range(2) == 0 ? 6'($urandom_range(63)) : 6'($urandom_range(7));
      case ($urandom_range(9))
        0:       t.qty = 32'd0;
        1:       t.qty = 32'hFFFF_FFFF;
        2, 3:    t.qty = $urandom;
        4:       t.qty = 32'd1;
        5:       t.qty = lim_order;
        6:       t.qty = lim_order + 32'd1;
        default: t.qty = $urandom_range(2000);
      endcase
      t.sell = 1'($urandom_range(1));
    end
    case ($urandom_range(6))
      0:       t.oms = POS_MAX_40;
      1:       t.oms = POS_MIN_40;
      2, 3:    t.oms = 40'({$urandom, $urandom});
      // Lands the order right on the per-instrument limit.
      4:       t.oms = t.sell ? 40'(lim_open) + 40'(t.qty) : 40'(lim_open) - 40'(t.qty);
      default: t.oms = pos_book[t.inst] + 40'($urandom_range(200)) - 40'd100;
    endcase
    case ($urandom_range(hot ? 39 : 9))
      0:       t.status = FILL_STATUS_OTHER;
      1:       t.status = FILL_STATUS_SPARE;
      default: t.status = $urandom_range(1) ? FILL_STATUS_FILLED : FILL_STATUS_PARTIAL;
    endcase
    return t;
  endfunction

  task automatic push_item(input order_t o, input logic typed, input risk_result_t want);
    risk_result_t r;
    @(negedge clk);
    in_valid        = 1'b1;
    in_action       = o.action;
    in_instrument   = o.inst;
    in_quantity     = o.qty;
    in_sell         = o.sell;
    in_oms_position = o.oms;
    in_fill_status  = o.status;
    do @(posedge clk); while (!in_ready);
    r = predict_risk(o);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic sender_gap();
    if (!steady && $urandom_range(99) < 7) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    set_limit(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [63:0] order_lim, input logic [63:0] daily_lim,
                           input logic [63:0] open_lim, input logic [63:0] total_lim,
                           input logic [63:0] mask);
    wait_drained();
    write_reg(CFG_MAX_ORDER_SIZE, order_lim);
    write_reg(CFG_MAX_DAILY_VOL, daily_lim);
    write_reg(CFG_MAX_OPEN_INST, open_lim);
    write_reg(CFG_MAX_TOTAL_OPEN, total_lim);
    write_reg(CFG_ALLOWED_MASK, mask);
  endtask

  task automatic run_random(input int count, input bit hot);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0)
        wait_drained();
      sender_gap();
      push_item(rand_order(hot), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (steady) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(99) < 7) begin
      stall_left = $urandom_range(3);
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    risk_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing pending, expected none, got verdict %0d",
                 $time, out_verdict);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("verdict", want.verdict, out_verdict);
        check_field("position", want.pos, out_position);
        check_field("daily_volume", want.vol, out_daily_volume);
        check_field("total_open", want.total, out_total_open);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_MAX_ORDER_SIZE;
    cfg_data        = 64'd0;
    in_valid        = 1'b0;
    in_action       = ACTION_CHECK;
    in_instrument   = 6'd0;
    in_quantity     = 32'd0;
    in_sell         = 1'b0;
    in_oms_position = 40'sd0;
    in_fill_status  = FILL_STATUS_OTHER;
    steady          = 1'b0;
    errors          = 0;
    lim_order       = '0;
    lim_daily       = '0;
    lim_open        = '0;
    lim_total       = '0;
    allow_mask      = '0;
    open_sum        = '0;
    for (int i = 0; i < 64; i++) begin
      vol_book[i] = '0;
      pos_book[i] = '0;
    end

    // All limits are zero out of reset, so only zero-size orders pass.
    add_known(ACTION_CHECK, 6'd0, 32'd0, 1'b0, 40'sd0, FILL_STATUS_OTHER,
              VERDICT_APPROVED, 0, 0, 0);
    add_known(ACTION_CHECK, 6'd63, 32'hFFFF_FFFF, 1'b1, POS_MIN_40, FILL_STATUS_OTHER,
              VERDICT_ORDER_SIZE, 0, 0, 0);
    add_known(ACTION_FILL, 6'd5, 32'd0, 1'b0, 40'sd0, FILL_STATUS_FILLED,
              VERDICT_APPROVED, 0, 0, 0);
    add_known(ACTION_FILL, 6'd5, 32'd100, 1'b0, 40'sd0, FILL_STATUS_SPARE,
              VERDICT_APPROVED, 0, 0, 0);
    add_known(ACTION_FILL, 6'd5, 32'd100, 1'b0, 40'sd0, FILL_STATUS_OTHER,
              VERDICT_APPROVED, 0, 0, 0);
    add_known(ACTION_FILL, 6'd5, 32'd100, 1'b0, 40'sd0, FILL_STATUS_FILLED,
              VERDICT_APPROVED, 100, 100, 100);
    add_known(ACTION_FILL, 6'd5, 32'd40, 1'b1, 40'sd0, FILL_STATUS_PARTIAL,
              VERDICT_APPROVED, 60, 140, 60);
    // Small limits so each rejection reason can be hit in turn.
    add_cfg(CFG_MAX_ORDER_SIZE, 64'd1000);
    add_cfg(CFG_MAX_DAILY_VOL, 64'd500);
    add_cfg(CFG_MAX_OPEN_INST, 64'd300);
    add_cfg(CFG_MAX_TOTAL_OPEN, 64'd400);
    add_known(ACTION_CHECK, 6'd5, 32'd1001, 1'b0, 40'sd0, FILL_STATUS_OTHER,
              VERDICT_ORDER_SIZE, 60, 140, 60);
    add_known(ACTION_CHECK, 6'd5, 32'd400, 1'b0, 40'sd0, FILL_STATUS_OTHER,
              VERDICT_DAILY_VOLUME, 60, 140, 60);
    add_known(ACTION_CHECK, 6'd5, 32'd300, 1'b0, 40'sd1, FILL_STATUS_OTHER,
              VERDICT_INST_OPEN, 60, 140, 60);
    add_item(ACTION_FILL, 6'd7, 32'd200, 1'b1, 40'sd0, FILL_STATUS_PARTIAL);
    add_item(ACTION_CHECK, 6'd5, 32'd300, 1'b0, 40'sd0, FILL_STATUS_OTHER);
    add_item(ACTION_CHECK, 6'd5, 32'd100, 1'b1, 40'sd0, FILL_STATUS_OTHER);
    add_cfg(CFG_ALLOWED_MASK, 64'h8000_0000_0000_0020);
    add_item(ACTION_CHECK, 6'd6, 32'd1, 1'b0, 40'sd0, FILL_STATUS_OTHER);
    add_item(ACTION_CHECK, 6'd63, 32'd1, 1'b1, 40'sd0, FILL_STATUS_OTHER);
    add_item(ACTION_FILL, 6'd6, 32'd9, 1'b0, 40'sd0, FILL_STATUS_FILLED);
    // Widest limits, then orders at the edges of the position range.
    add_cfg(CFG_MAX_ORDER_SIZE, 64'hFFFF_FFFF);
    add_cfg(CFG_MAX_DAILY_VOL, 64'(VOL_MAX_40));
    add_cfg(CFG_MAX_OPEN_INST, 64'h7F_FFFF_FFFF);
    add_cfg(CFG_MAX_TOTAL_OPEN, 64'h3FFF_FFFF_FFFF);
    add_cfg(CFG_ALLOWED_MASK, 64'd0);
    add_item(ACTION_CHECK, 6'd63, 32'hFFFF_FFFF, 1'b1, POS_MIN_40, FILL_STATUS_OTHER);
    add_item(ACTION_CHECK, 6'd63, 32'hFFFF_FFFF, 1'b0, POS_MAX_40, FILL_STATUS_OTHER);
    add_item(ACTION_CHECK, 6'd63, 32'hFFFF_FFFF, 1'b0, POS_MIN_40, FILL_STATUS_OTHER);
    add_item(ACTION_FILL, 6'd63, 32'hFFFF_FFFF, 1'b1, 40'sd0, FILL_STATUS_PARTIAL);
    add_item(ACTION_CHECK, 6'd63, 32'd0, 1'b0, -40'sd1, FILL_STATUS_OTHER);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        sender_gap();
        push_item(directed_rows[i].ord, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    configure(64'hFFFF_FFFF, 64'(VOL_MAX_40), 64'h7F_FFFF_FFFF, 64'h3FFF_FFFF_FFFF, 64'd0);
    steady = 1'b1;
    run_random(280, 1'b0);
    steady = 1'b0;

    configure(64'($urandom_range(4000)), 64'($urandom) << $urandom_range(8),
              64'($urandom_range(32'h00FF_FFFF)) << $urandom_range(12),
              64'($urandom) << $urandom_range(13), {$urandom, $urandom});
    run_random(280, 1'b0);

    configure(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    run_random(120, 1'b0);

    configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, '1);
    run_random(280, 1'b0);

    // Long same-side fills on two instruments drive volume and position
    // into saturation.
    configure(64'hFFFF_FFFF, 64'(VOL_MAX_40), 64'h7F_FFFF_FFFF, 64'h3FFF_FFFF_FFFF, 64'd0);
    run_random(640, 1'b1);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### pre_trade_risk_check.f
rtl/ptrc_pkg.sv
rtl/pre_trade_risk_check.sv
tb/sv/pre_trade_risk_check_tb.sv
